FILE: src/alarm_deadline_queue_ring_snooze_core_assert.svh
// assertion macros for the alarm deadline queue
`ifndef ALARM_DEADLINE_QUEUE_RING_SNOOZE_CORE_ASSERT_SVH
`define ALARM_DEADLINE_QUEUE_RING_SNOOZE_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define ADQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ADQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/adq_pkg.sv
// package: types and codes for the alarm deadline queue
`timescale 1ns / 1ps
`default_nettype none
package adq_pkg;
    localparam int TimeW = 48;
    localparam int IdW = 32;

    typedef enum logic [2:0] {
        CMD_TICK = 3'd0, CMD_CREATE = 3'd1, CMD_CLEAR = 3'd2,
        CMD_CLEAR_ALL = 3'd3, CMD_DISMISS = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_RING = 3'd1;
    localparam logic [2:0] EV_SNOOZE = 3'd2;
    localparam logic [2:0] EV_DISMISSED = 3'd3;
    localparam logic [2:0] EV_EXHAUSTED = 3'd4;

    localparam logic [1:0] REG_RING = 2'd0;
    localparam logic [1:0] REG_SNOOZE = 2'd1;
    localparam logic [1:0] REG_MAXA = 2'd2;

    localparam logic [31:0] RingReset = 32'd60000;
    localparam logic [31:0] SnoozeReset = 32'd300000;
    localparam logic [3:0] MaxaReset = 4'd3;

    typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_RING = 2'd1, PH_SNOOZE = 2'd2} phase_t;

    typedef enum logic [1:0] {S_IDLE, S_WORK, S_SHIFT, S_OUT} fsm_t;

    // one queue entry
    typedef struct packed {
        logic [TimeW-1:0] t;
        logic [IdW-1:0]   id;
    } entry_t;

    // chain operation broadcast to every cell
    typedef enum logic [1:0] {OP_HOLD, OP_INSERT, OP_REMOVE} op_t;

    typedef struct packed {
        op_t    op;
        entry_t ins;
    } chain_ctl_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [TimeW-1:0] now_ms;
        logic [TimeW-1:0] trig_ms;
        logic [4:0]       clear_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IdW-1:0]   alm_id;
        logic [TimeW-1:0] alarm_time;
        logic [4:0]       vis_count;
        logic             ringing;
        logic [2:0]       event_res;
        logic [3:0]       attempt_number;
    } out_word_t;
endpackage
`default_nettype wire

FILE: src/adq_if.sv
// valid/ready channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface adq_in_if;
    logic valid;
    logic ready;
    adq_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface adq_out_if;
    logic valid;
    logic ready;
    adq_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface adq_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [31:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: src/adq_cell.sv
// one queue cell: holds an entry, takes the insert entry or one from left or right neighbor
`timescale 1ns / 1ps
`default_nettype none
module adq_cell (
    input  wire logic            clk,
    input  wire adq_pkg::chain_ctl_t ctl,
    input  wire logic            sel,        // this cell is at or after the position
    input  wire logic            at_pos,     // this cell is exactly the position
    input  wire adq_pkg::entry_t left_q,
    input  wire adq_pkg::entry_t right_q,
    output adq_pkg::entry_t      q
);
    import adq_pkg::*;
    entry_t q_reg, q_next;

    always_comb
    begin
        q_next = q_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (at_pos) q_next = ctl.ins;
                else if (sel) q_next = left_q;
            end
            OP_REMOVE:
            begin
                if (sel) q_next = right_q;
            end
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;
endmodule
`default_nettype wire

FILE: src/adq_chain.sv
// row of sorted queue cells with position compare
`timescale 1ns / 1ps
`default_nettype none
module adq_chain #(
    parameter int CAPACITY = 16,
    parameter int PW = 5
) (
    input  wire logic                 clk,
    input  wire adq_pkg::chain_ctl_t  ctl,
    input  wire logic [PW-1:0]        pos,     // target position for insert or remove
    input  wire logic [PW-1:0]        count,
    input  wire adq_pkg::entry_t      key,
    output logic [PW-1:0]             ins_pos, // sorted insert position for key
    output adq_pkg::entry_t           head,
    output adq_pkg::entry_t           at_q     // entry at pos
);
    import adq_pkg::*;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    entry_t q [CAPACITY];
    logic [CAPACITY-1:0] before_key;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t lq, rq;
            logic s, a;
            if (g == 0)
            begin : g_l0
                assign lq = q[0];
            end
            else
            begin : g_l
                assign lq = q[g-1];
            end
            if (g == CAPACITY-1)
            begin : g_rl
                assign rq = q[g];
            end
            else
            begin : g_r
                assign rq = q[g+1];
            end
            assign s = (PW'(g) >= pos);
            assign a = (PW'(g) == pos);
            adq_cell u_cell (
                .clk(clk), .ctl(ctl), .sel(s), .at_pos(a),
                .left_q(lq), .right_q(rq), .q(q[g])
            );
            assign before_key[g] = (PW'(g) < count) &&
                ((q[g].t < key.t) || (q[g].t == key.t && q[g].id < key.id));
        end
    endgenerate

    // sorted order makes before_key a run of ones from cell 0
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (before_key[i]) ins_pos = PW'(i + 1);
        end
    end

    assign head = q[0];
    assign at_q = q[pos[IW-1:0]];
endmodule
`default_nettype wire

FILE: src/alarm_deadline_queue_ring_snooze_core.sv
// top level: sorted alarm queue with ring and snooze sequencer
// usage:
//  - in: one command word (tick, create, clear one, clear all, dismiss)
//  - out: one result word per command, status, event and counts
//  - cfg: write ring time, snooze time and attempt limit while idle
//  - a command word is captured at the accepting edge, the sequencer
//    decides in the next cycle, the cell row shifts in the cycle after,
//    and the result word is valid once the row has shifted
//  - with a ready receiver the result is taken in the cycle it shows up
//    valid, and in is ready again once it is taken
//  - the cells compare in parallel and all shift one place together,
//    so insert and removal cost the same at any queue depth
//  - one command in flight at a time; the result register holds the word
//    until taken, and in is not ready until it is taken
//  - reset empties the queue, drops the active alarm, restarts ids at one
//  - queue cells hold no reset; a fill count marks the live entries
//  - a stalled receiver just holds the result word, and each stall cycle
//    holds off the next command
`timescale 1ns / 1ps
`default_nettype none
module alarm_deadline_queue_ring_snooze_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    adq_in_if.sink    in_ch,
    adq_out_if.source out_ch,
    adq_cfg_if.sink   cfg
);
    import adq_pkg::*;
    `include "alarm_deadline_queue_ring_snooze_core_assert.svh"

    localparam int PW = $clog2(CAPACITY + 1) + 1;

    // configuration
    logic [31:0] ring_reg, snooze_reg;
    logic [3:0]  maxa_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= RingReset;
            snooze_reg <= SnoozeReset;
            maxa_reg <= MaxaReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RING:   ring_reg <= cfg.wdata;
                REG_SNOOZE: snooze_reg <= cfg.wdata;
                REG_MAXA:   maxa_reg <= cfg.wdata[3:0];
                default:    ;
            endcase
        end
    end

    // control state
    fsm_t state_reg, state_next;
    in_word_t inw_reg;
    out_word_t res_reg, res_next;
    logic [PW-1:0] count_reg, count_next;
    logic [IdW-1:0] nid_reg, nid_next;
    logic act_reg, act_next;
    entry_t aent_reg, aent_next;
    phase_t ph_reg, ph_next;
    logic [3:0] att_reg, att_next;
    logic [TimeW-1:0] pstart_reg, pstart_next;
    logic dis_reg, dis_next;
    chain_ctl_t ctl;
    logic [PW-1:0] pos_reg, pos_next;
    op_t op_reg, op_next;
    entry_t ins_reg, ins_next;

    entry_t key, head, at_q;
    logic [PW-1:0] ins_pos;

    assign key.t = inw_reg.trig_ms;
    assign key.id = nid_reg;
    // the row moves at most once per command, only in the shift cycle
    assign ctl.op = (state_reg == S_SHIFT) ? op_reg : OP_HOLD;
    assign ctl.ins = ins_reg;

    adq_chain #(.CAPACITY(CAPACITY), .PW(PW)) u_chain (
        .clk(clk), .ctl(ctl), .pos(pos_reg), .count(count_reg), .key(key),
        .ins_pos(ins_pos), .head(head), .at_q(at_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_ch.valid) state_next = S_WORK;
            S_WORK:  state_next = S_SHIFT;
            S_SHIFT: state_next = S_OUT;
            S_OUT:   if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data = res_reg;

    // command decision, evaluated in the work cycle
    logic [PW-1:0] vis;
    logic [3:0] maxa;
    logic [TimeW-1:0] el;
    logic [PW-1:0] cpos;
    always_comb
    begin
        vis = count_reg + PW'(act_reg);
        maxa = (maxa_reg == 4'd0) ? 4'd1 : maxa_reg;
        el = (inw_reg.now_ms >= pstart_reg) ? inw_reg.now_ms - pstart_reg : '0;
        cpos = PW'(inw_reg.clear_index) - PW'(1) - PW'(act_reg);
        count_next = count_reg; nid_next = nid_reg; act_next = act_reg;
        aent_next = aent_reg; ph_next = ph_reg; att_next = att_reg;
        pstart_next = pstart_reg; dis_next = dis_reg;
        pos_next = pos_reg; op_next = OP_HOLD; ins_next = ins_reg;
        res_next = res_reg;
        res_next.status = ST_OK; res_next.alm_id = '0; res_next.alarm_time = '0;
        res_next.event_res = EV_NONE;
        case (inw_reg.cmd)
            CMD_TICK:
            begin
                if (act_reg)
                begin
                    if (dis_reg)
                    begin
                        res_next.event_res = EV_DISMISSED;
                        res_next.alm_id = aent_reg.id; res_next.alarm_time = aent_reg.t;
                        act_next = 1'b0;
                    end
                    else if (ph_reg == PH_RING && el >= {16'd0, ring_reg})
                    begin
                        res_next.alm_id = aent_reg.id; res_next.alarm_time = aent_reg.t;
                        if (att_reg < maxa)
                        begin
                            ph_next = PH_SNOOZE; pstart_next = inw_reg.now_ms;
                            res_next.event_res = EV_SNOOZE;
                        end
                        else
                        begin
                            act_next = 1'b0; res_next.event_res = EV_EXHAUSTED;
                        end
                    end
                    else if (ph_reg == PH_SNOOZE && el >= {16'd0, snooze_reg})
                    begin
                        att_next = att_reg + 4'd1; ph_next = PH_RING;
                        pstart_next = inw_reg.now_ms;
                        res_next.event_res = EV_RING;
                        res_next.alm_id = aent_reg.id; res_next.alarm_time = aent_reg.t;
                    end
                end
                else if (count_reg != '0 && inw_reg.now_ms >= head.t)
                begin
                    act_next = 1'b1; aent_next = head; ph_next = PH_RING;
                    att_next = 4'd1; pstart_next = inw_reg.now_ms; dis_next = 1'b0;
                    op_next = OP_REMOVE; pos_next = '0; count_next = count_reg - PW'(1);
                    res_next.event_res = EV_RING;
                    res_next.alm_id = head.id; res_next.alarm_time = head.t;
                end
            end
            CMD_CREATE:
            begin
                if (inw_reg.trig_ms <= inw_reg.now_ms) res_next.status = ST_INVALID;
                else if (vis >= PW'(CAPACITY)) res_next.status = ST_FULL;
                else
                begin
                    nid_next = (nid_reg == '1) ? IdW'(1) : nid_reg + IdW'(1);
                    op_next = OP_INSERT; pos_next = ins_pos; ins_next = key;
                    count_next = count_reg + PW'(1);
                    res_next.alm_id = nid_reg; res_next.alarm_time = inw_reg.trig_ms;
                end
            end
            CMD_CLEAR:
            begin
                if (inw_reg.clear_index == 5'd0 || PW'(inw_reg.clear_index) > vis)
                    res_next.status = ST_INVALID;
                else if (act_reg && inw_reg.clear_index == 5'd1)
                begin
                    res_next.alm_id = aent_reg.id; res_next.alarm_time = aent_reg.t;
                    act_next = 1'b0;
                end
                else
                begin
                    pos_next = cpos; op_next = OP_REMOVE;
                    count_next = count_reg - PW'(1);
                end
            end
            CMD_CLEAR_ALL:
            begin
                count_next = '0; act_next = 1'b0;
            end
            CMD_DISMISS:
            begin
                if (act_reg && ph_reg == PH_RING) dis_next = 1'b1;
            end
            default: res_next.status = ST_INVALID;
        endcase
        if (!act_next)
        begin
            aent_next = '0; ph_next = PH_IDLE; att_next = '0;
            pstart_next = '0; dis_next = 1'b0;
        end
        res_next.vis_count = 5'(count_next + PW'(act_next));
        res_next.ringing = act_next && (ph_next == PH_RING);
        res_next.attempt_number = act_next ? att_next : 4'd0;
    end

    // for a clear, the removed entry fields are read in the shift cycle, before the row moves
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid) inw_reg <= in_ch.data;
        if (state_reg == S_WORK)
        begin
            res_reg <= res_next; pos_reg <= pos_next; op_reg <= op_next;
            ins_reg <= ins_next;
        end
        else if (state_reg == S_SHIFT && op_reg == OP_REMOVE && inw_reg.cmd == CMD_CLEAR)
        begin
            res_reg.alm_id <= at_q.id; res_reg.alarm_time <= at_q.t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; count_reg <= '0; nid_reg <= IdW'(1); act_reg <= 1'b0;
            aent_reg <= '0; ph_reg <= PH_IDLE; att_reg <= '0; pstart_reg <= '0;
            dis_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WORK)
            begin
                count_reg <= count_next; nid_reg <= nid_next; act_reg <= act_next;
                aent_reg <= aent_next; ph_reg <= ph_next; att_reg <= att_next;
                pstart_reg <= pstart_next; dis_reg <= dis_next;
            end
        end
    end

    `ADQ_ASSERT_IMP(a_count_cap, 1'b1, count_reg + PW'(act_reg) <= PW'(CAPACITY))
    `ADQ_ASSERT_IMP(a_idle_inactive, !act_reg, ph_reg == PH_IDLE && !dis_reg)
    `ADQ_ASSERT_NXT(a_work_then_shift, state_reg == S_WORK, state_reg == S_SHIFT)
    `ADQ_ASSERT_NXT(a_shift_then_out, state_reg == S_SHIFT, state_reg == S_OUT)
endmodule
`default_nettype wire
